// ===== hdl/frc_pkg.sv =====
// Package holding the transaction types, codes and CRC helper of the frame receiver.
package frc_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last;
        logic [1:0] frame_status;
        logic [7:0] command_id;
    } t_out_item;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CRC_ERR   = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    localparam logic [7:0]  START_BYTE  = 8'h7E;
    localparam logic [7:0]  END_BYTE    = 8'hFF;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [7:0]  SHORT_LIMIT = 8'd6;
    localparam logic [6:0]  POS_SAT     = 7'd127;
    localparam logic [6:0]  POS_CMD     = 7'd2;
    localparam logic [6:0]  POS_RELEASE = 7'd4;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/frc_out_stage.sv =====
// Output register stage that holds one result transaction until it is taken.
module frc_out_stage
    import frc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_out_item i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic      r_valid;
    t_out_item r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

// ===== hdl/frame_receiver_crc16_check.sv =====
// Top level of the delimited frame receiver with CRC-16 check.
// A result is registered in the output stage and appears on the output in the cycle after the input transaction.
// Throughput: one input byte per cycle; the output register decides readiness.
// A byte before chunk index 4 that does not close the chunk gives no result.
// Reset is synchronous and active low; it clears the position, delay line,
// CRC and the output register. The closing byte returns all other state to reset.
module frame_receiver_crc16_check
    import frc_pkg::*;
#(
    parameter int MAX_PAYLOAD = 16,
    parameter int MAX_CHUNK   = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [7:0] LP_MAX_CHUNK = 8'(MAX_CHUNK);
    localparam logic [7:0] LP_MAX_POS   = 8'(MAX_PAYLOAD + 3);

    logic [6:0]  r_pos,      n_pos;
    logic [7:0]  r_delay [3];
    logic [7:0]  n_delay [3];
    logic [15:0] r_crc,      n_crc;
    logic        r_start_ok, n_start_ok;
    logic [7:0]  r_cmd,      n_cmd;

    logic        accept;
    logic        released;
    logic        start_ok_eff;
    logic [7:0]  cmd_eff;
    logic [15:0] crc_eff;
    logic [7:0]  total;
    logic [7:0]  pos_ext;
    logic [1:0]  status;
    logic        res_valid;
    t_out_item   res;

    assign accept   = i_in_valid && o_in_ready;
    assign released = (r_pos >= POS_RELEASE);
    assign pos_ext  = {1'b0, r_pos};
    assign total    = pos_ext + 8'd1;

    always_comb begin
        start_ok_eff = (r_pos == '0) ? (i_in_data.rx_byte == START_BYTE) : r_start_ok;
        if (r_pos == '0) begin
            cmd_eff = '0;
        end else if (r_pos == POS_CMD) begin
            cmd_eff = i_in_data.rx_byte;
        end else begin
            cmd_eff = r_cmd;
        end
        crc_eff = released ? crc_fold(r_crc, r_delay[0]) : r_crc;

        if (!start_ok_eff || i_in_data.rx_byte != END_BYTE || total <= SHORT_LIMIT) begin
            status = ST_MALFORMED;
        end else if (total > LP_MAX_CHUNK || pos_ext > LP_MAX_POS) begin
            status = ST_TOO_LONG;
        end else if (crc_eff == {r_delay[1], r_delay[2]}) begin
            status = ST_OK;
        end else begin
            status = ST_CRC_ERR;
        end
    end

    always_comb begin
        res_valid        = accept && (i_in_data.chunk_end || released);
        res.payload_byte = (released && start_ok_eff) ? r_delay[0] : 8'h00;
        res.last         = i_in_data.chunk_end;
        res.frame_status = i_in_data.chunk_end ? status : ST_OK;
        res.command_id   = i_in_data.chunk_end ? cmd_eff : 8'h00;
    end

    always_comb begin
        n_pos      = r_pos;
        n_delay    = r_delay;
        n_crc      = r_crc;
        n_start_ok = r_start_ok;
        n_cmd      = r_cmd;
        if (accept) begin
            if (i_in_data.chunk_end) begin
                n_pos      = '0;
                n_delay    = '{default: 8'h00};
                n_crc      = CRC_INIT;
                n_start_ok = 1'b0;
                n_cmd      = '0;
            end else begin
                n_pos      = (r_pos == POS_SAT) ? r_pos : r_pos + 7'd1;
                n_start_ok = start_ok_eff;
                n_cmd      = cmd_eff;
                n_crc      = crc_eff;
                if (r_pos != '0) begin
                    n_delay[0] = r_delay[1];
                    n_delay[1] = r_delay[2];
                    n_delay[2] = i_in_data.rx_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_delay    <= '{default: 8'h00};
            r_crc      <= CRC_INIT;
            r_start_ok <= 1'b0;
            r_cmd      <= '0;
        end else begin
            r_pos      <= n_pos;
            r_delay    <= n_delay;
            r_crc      <= n_crc;
            r_start_ok <= n_start_ok;
            r_cmd      <= n_cmd;
        end
    end

    frc_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (o_in_ready),
        .i_data  (res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ===== hdl/frc_checker.sv =====
// Port-level checker for the frame receiver and the bind that attaches it.
module frc_port_checker
    import frc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Result transaction withdrawn before it was taken.");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("Result payload changed while stalled.");

    a_status_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |->
            o_out_data.frame_status == ST_OK && o_out_data.command_id == 8'h00)
        else $error("Status or command identifier set on a non-closing result.");

    a_close_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.chunk_end |=>
            o_out_valid && o_out_data.last)
        else $error("Closing byte did not produce a closing result.");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid after reset.");

endmodule

bind frame_receiver_crc16_check frc_port_checker u_frc_port_checker (.*);
